FILE: hdl/mbr_pkg.sv
// Shared command codes and the flag type for the branch resolve block.
package mbr_pkg;

  localparam int unsigned CmdW = 5;

  localparam logic [CmdW-1:0] CMD_BEQ    = 5'd0;
  localparam logic [CmdW-1:0] CMD_BEQL   = 5'd1;
  localparam logic [CmdW-1:0] CMD_BNE    = 5'd2;
  localparam logic [CmdW-1:0] CMD_BNEL   = 5'd3;
  localparam logic [CmdW-1:0] CMD_BGEZ   = 5'd4;
  localparam logic [CmdW-1:0] CMD_BGEZL  = 5'd5;
  localparam logic [CmdW-1:0] CMD_BGTZ   = 5'd6;
  localparam logic [CmdW-1:0] CMD_BGTZL  = 5'd7;
  localparam logic [CmdW-1:0] CMD_BLEZ   = 5'd8;
  localparam logic [CmdW-1:0] CMD_BLEZL  = 5'd9;
  localparam logic [CmdW-1:0] CMD_BLTZ   = 5'd10;
  localparam logic [CmdW-1:0] CMD_BLTZL  = 5'd11;
  localparam logic [CmdW-1:0] CMD_BC1F   = 5'd12;
  localparam logic [CmdW-1:0] CMD_BC1FL  = 5'd13;
  localparam logic [CmdW-1:0] CMD_BC1T   = 5'd14;
  localparam logic [CmdW-1:0] CMD_BC1TL  = 5'd15;
  localparam logic [CmdW-1:0] CMD_J      = 5'd16;
  localparam logic [CmdW-1:0] CMD_JR     = 5'd17;

  typedef struct packed {
    logic eq;
    logic neg;
    logic zero;
  } rs_flags_t;

endpackage

FILE: hdl/mbr_cond.sv
// Register comparison flags for branch conditions.
module mbr_cond (
  input  logic signed [63:0] rs_value_i,
  input  logic signed [63:0] rt_value_i,
  output mbr_pkg::rs_flags_t flags_o
);
  import mbr_pkg::*;

  assign flags_o.eq   = (rs_value_i == rt_value_i);
  assign flags_o.neg  = rs_value_i[63];
  assign flags_o.zero = (rs_value_i == 64'sd0);

endmodule

FILE: hdl/mips_branch_resolve.sv
// Top level of the branch and jump resolve pipeline.
//
// Usage: drive the operands and pulse start_i; an item is taken at every
// rising edge where start_i is high and busy_o is low. busy_o never rises,
// so one item may be issued every cycle.
// Result: taken_o, target_pc_o, nullify_slot_o and cop_unusable_o pass the
// capture and compare registers and then the output register, marked by
// done_o for one cycle. Throughput is one item per cycle.
// Stages: input capture; compare of rs/rt and the target adders; condition
// select and output register.
// Reset (rst_ni low, asynchronous) drops every item in flight and holds
// done_o low. The receiver cannot stall: each result shows for one cycle.
// Outputs between strobes carry stale values and mean nothing.
module mips_branch_resolve (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [mbr_pkg::CmdW-1:0]   cmd_i,
  input  logic signed [63:0]         rs_value_i,
  input  logic signed [63:0]         rt_value_i,
  input  logic signed [15:0]         imm_offset_i,
  input  logic [25:0]                jump_index_i,
  input  logic [31:0]                branch_pc_i,
  input  logic                       fpu_usable_i,
  input  logic                       fpu_cond_i,
  output logic                       done_o,
  output logic                       taken_o,
  output logic [31:0]                target_pc_o,
  output logic                       nullify_slot_o,
  output logic                       cop_unusable_o
);
  import mbr_pkg::*;

  // Stage 1: input capture
  logic               s1_valid_q;
  logic [CmdW-1:0]    s1_cmd_q;
  logic signed [63:0] s1_rs_q;
  logic signed [63:0] s1_rt_q;
  logic signed [15:0] s1_imm_q;
  logic [25:0]        s1_jidx_q;
  logic [31:0]        s1_pc_q;
  logic               s1_usable_q;
  logic               s1_cond_q;

  // Stage 2: flags and candidate targets
  logic               s2_valid_q;
  logic [CmdW-1:0]    s2_cmd_q;
  rs_flags_t          s2_flags_q;
  logic [31:0]        s2_bt_q;
  logic [31:0]        s2_jt_q;
  logic [31:0]        s2_jr_q;
  logic               s2_usable_q;
  logic               s2_cond_q;

  // Stage 3: outputs
  logic               s3_valid_q;
  logic               s3_taken_q,  s3_taken_d;
  logic [31:0]        s3_target_q, s3_target_d;
  logic               s3_null_q,   s3_null_d;
  logic               s3_cop_q,    s3_cop_d;

  rs_flags_t          s1_flags;
  logic [31:0]        s1_pc4;
  logic [31:0]        s1_bt;
  logic [31:0]        s1_jt;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= start_i && !busy_o;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_cmd_q    <= cmd_i;
    s1_rs_q     <= rs_value_i;
    s1_rt_q     <= rt_value_i;
    s1_imm_q    <= imm_offset_i;
    s1_jidx_q   <= jump_index_i;
    s1_pc_q     <= branch_pc_i;
    s1_usable_q <= fpu_usable_i;
    s1_cond_q   <= fpu_cond_i;
  end

  mbr_cond u_cond (
    .rs_value_i (s1_rs_q),
    .rt_value_i (s1_rt_q),
    .flags_o    (s1_flags)
  );

  assign s1_pc4 = s1_pc_q + 32'd4;
  assign s1_bt  = s1_pc4 + {{14{s1_imm_q[15]}}, s1_imm_q, 2'b00};
  assign s1_jt  = {s1_pc4[31:28], s1_jidx_q, 2'b00};

  always_ff @(posedge clk_i) begin
    s2_cmd_q    <= s1_cmd_q;
    s2_flags_q  <= s1_flags;
    s2_bt_q     <= s1_bt;
    s2_jt_q     <= s1_jt;
    s2_jr_q     <= s1_rs_q[31:0];
    s2_usable_q <= s1_usable_q;
    s2_cond_q   <= s1_cond_q;
  end

  always_comb begin
    logic take;
    logic likely;
    take        = 1'b0;
    likely      = 1'b0;
    s3_cop_d    = 1'b0;
    s3_target_d = 32'd0;
    unique case (s2_cmd_q) inside
      CMD_BEQ, CMD_BEQL: begin
        take   = s2_flags_q.eq;
        likely = (s2_cmd_q == CMD_BEQL);
      end
      CMD_BNE, CMD_BNEL: begin
        take   = !s2_flags_q.eq;
        likely = (s2_cmd_q == CMD_BNEL);
      end
      CMD_BGEZ, CMD_BGEZL: begin
        take   = !s2_flags_q.neg;
        likely = (s2_cmd_q == CMD_BGEZL);
      end
      CMD_BGTZ, CMD_BGTZL: begin
        take   = !s2_flags_q.neg && !s2_flags_q.zero;
        likely = (s2_cmd_q == CMD_BGTZL);
      end
      CMD_BLEZ, CMD_BLEZL: begin
        take   = s2_flags_q.neg || s2_flags_q.zero;
        likely = (s2_cmd_q == CMD_BLEZL);
      end
      CMD_BLTZ, CMD_BLTZL: begin
        take   = s2_flags_q.neg;
        likely = (s2_cmd_q == CMD_BLTZL);
      end
      CMD_BC1F, CMD_BC1FL, CMD_BC1T, CMD_BC1TL: begin
        // Unusable coprocessor traps and suppresses the branch entirely
        if (!s2_usable_q) begin
          s3_cop_d = 1'b1;
        end else begin
          take   = (s2_cmd_q == CMD_BC1T || s2_cmd_q == CMD_BC1TL) ? s2_cond_q
                                                                    : !s2_cond_q;
          likely = (s2_cmd_q == CMD_BC1FL || s2_cmd_q == CMD_BC1TL);
        end
      end
      CMD_J: begin
        take        = 1'b1;
        s3_target_d = s2_jt_q;
      end
      CMD_JR: begin
        take        = 1'b1;
        s3_target_d = s2_jr_q;
      end
      default: begin
        take = 1'b0;
      end
    endcase
    if (take && s2_cmd_q < CMD_J) begin
      s3_target_d = s2_bt_q;
    end
    s3_taken_d = take;
    s3_null_d  = likely && !take;
  end

  always_ff @(posedge clk_i) begin
    s3_taken_q  <= s3_taken_d;
    s3_target_q <= s3_target_d;
    s3_null_q   <= s3_null_d;
    s3_cop_q    <= s3_cop_d;
  end

  assign done_o         = s3_valid_q;
  assign taken_o        = s3_taken_q;
  assign target_pc_o    = s3_target_q;
  assign nullify_slot_o = s3_null_q;
  assign cop_unusable_o = s3_cop_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##3 done_o)
    else $error("accepted item did not complete after three cycles");

  a_null_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(taken_o && nullify_slot_o))
    else $error("taken branch nullifies its delay slot");

  a_cop_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && cop_unusable_o |-> !taken_o && !nullify_slot_o && target_pc_o == 32'd0)
    else $error("coprocessor trap with branch side effects");

  a_target_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !taken_o |-> target_pc_o == 32'd0)
    else $error("untaken result carries a target");

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the branch resolve block: directed corners, then random items.
module tb_top;
  import mbr_pkg::*;

  localparam logic [CmdW-1:0] CMD_UNDEF_LO = 5'd18;
  localparam logic [CmdW-1:0] CMD_UNDEF_HI = 5'd31;
  localparam int              CYCLE_LIMIT  = 400000;
  localparam int              SETTLE_CYCLES = 8;
  localparam int              PHASE_ITEMS  = 450;
  localparam int              MAX_GAP      = 50;

  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic [63:0]     rs;
    logic [63:0]     rt;
    logic [15:0]     imm;
    logic [25:0]     jidx;
    logic [31:0]     pc;
    logic            usable;
    logic            cond;
    int              gap;
    bit              drain;
  } branch_op_t;

  typedef struct packed {
    logic        taken;
    logic [31:0] target;
    logic        nullify;
    logic        cop_fault;
  } resolution_t;

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 start_i        = 1'b0;
  logic [CmdW-1:0]      cmd_i          = '0;
  logic signed [63:0]   rs_value_i     = '0;
  logic signed [63:0]   rt_value_i     = '0;
  logic signed [15:0]   imm_offset_i   = '0;
  logic [25:0]          jump_index_i   = '0;
  logic [31:0]          branch_pc_i    = '0;
  logic                 fpu_usable_i   = 1'b0;
  logic                 fpu_cond_i     = 1'b0;
  logic                 busy_o;
  logic                 done_o;
  logic                 taken_o;
  logic [31:0]          target_pc_o;
  logic                 nullify_slot_o;
  logic                 cop_unusable_o;

  branch_op_t  pending_ops[$];
  resolution_t resolutions_due[$];
  branch_op_t  issued_op;
  branch_op_t  op;
  resolution_t want;
  bit          running    = 1'b0;
  bit          item_taken = 1'b0;
  bit          gap_armed  = 1'b0;
  int          idle_left  = 0;
  int          errors     = 0;
  int          phase_idle[4] = '{0, 67, 22, 0};

  mips_branch_resolve dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .cmd_i          (cmd_i),
    .rs_value_i     (rs_value_i),
    .rt_value_i     (rt_value_i),
    .imm_offset_i   (imm_offset_i),
    .jump_index_i   (jump_index_i),
    .branch_pc_i    (branch_pc_i),
    .fpu_usable_i   (fpu_usable_i),
    .fpu_cond_i     (fpu_cond_i),
    .done_o         (done_o),
    .taken_o        (taken_o),
    .target_pc_o    (target_pc_o),
    .nullify_slot_o (nullify_slot_o),
    .cop_unusable_o (cop_unusable_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic resolution_t resolve_branch(branch_op_t b);
    resolution_t r;
    logic        take;
    logic        likely;
    logic        fault;
    logic [31:0] dest;
    logic [31:0] seq_pc;
    take   = 1'b0;
    likely = 1'b0;
    fault  = 1'b0;
    dest   = '0;
    seq_pc = b.pc + 32'd4;
    if (b.cmd <= CMD_BC1TL) begin
      likely = b.cmd[0];
      case (b.cmd)
        CMD_BEQ,  CMD_BEQL:  take = (b.rs == b.rt);
        CMD_BNE,  CMD_BNEL:  take = (b.rs != b.rt);
        CMD_BGEZ, CMD_BGEZL: take = !b.rs[63];
        CMD_BGTZ, CMD_BGTZL: take = !b.rs[63] && (b.rs != '0);
        CMD_BLEZ, CMD_BLEZL: take = b.rs[63] || (b.rs == '0);
        CMD_BLTZ, CMD_BLTZL: take = b.rs[63];
        CMD_BC1F, CMD_BC1FL: take = !b.cond;
        default:             take = b.cond;
      endcase
      // coprocessor 1 disabled: raise the fault, drop the branch
      if (b.cmd >= CMD_BC1F && !b.usable) begin
        fault  = 1'b1;
        take   = 1'b0;
        likely = 1'b0;
      end
      dest = seq_pc + {{14{b.imm[15]}}, b.imm, 2'b00};
    end else if (b.cmd == CMD_J) begin
      take = 1'b1;
      dest = {seq_pc[31:28], b.jidx, 2'b00};
    end else if (b.cmd == CMD_JR) begin
      take = 1'b1;
      dest = b.rs[31:0];
    end
    r.taken     = take;
    r.target    = take ? dest : 32'd0;
    r.nullify   = likely && !take && !fault;
    r.cop_fault = fault;
    return r;
  endfunction

  function automatic logic [63:0] corner_value(int k);
    case (k % 5)
      0:       return 64'd0;
      1:       return {1'b1, 63'd0};
      2:       return {1'b0, {63{1'b1}}};
      3:       return {64{1'b1}};
      default: return 64'd1;
    endcase
  endfunction

  function automatic logic [63:0] operand_value();
    logic [63:0] v;
    case ($urandom_range(5))
      0:       v = 64'($urandom_range(4)) - 64'd2;
      1:       v = {1'b1, 63'd0};
      2:       v = {1'b0, {63{1'b1}}};
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  function automatic branch_op_t random_op(int idle_pct);
    branch_op_t b;
    if ($urandom_range(99) < 6)
      b.cmd = CmdW'($urandom_range(CMD_UNDEF_HI, CMD_UNDEF_LO));
    else
      b.cmd = CmdW'($urandom_range(CMD_JR, CMD_BEQ));
    b.rs     = operand_value();
    b.rt     = ($urandom_range(99) < 30) ? b.rs : operand_value();
    b.imm    = 16'($urandom);
    b.jidx   = 26'($urandom);
    b.pc     = ($urandom_range(9) == 0) ? 32'hffff_fff0 + $urandom_range(15) : $urandom;
    b.usable = ($urandom_range(99) < 85);
    b.cond   = 1'($urandom);
    b.gap    = 0;
    while (b.gap < MAX_GAP && $urandom_range(99) < idle_pct)
      b.gap++;
    b.drain  = ($urandom_range(199) == 0);
    return b;
  endfunction

  task automatic present_op(branch_op_t b);
    cmd_i        <= b.cmd;
    rs_value_i   <= b.rs;
    rt_value_i   <= b.rt;
    imm_offset_i <= b.imm;
    jump_index_i <= b.jidx;
    branch_pc_i  <= b.pc;
    fpu_usable_i <= b.usable;
    fpu_cond_i   <= b.cond;
  endtask

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] got_val);
    if (got_val !== exp_val) begin
      errors++;
      $display("%0t: %s expected %h actual %h", $time, name, exp_val, got_val);
    end
  endtask

  // Driver: present items at the falling edge, junk operands while idle.
  always @(negedge clk_i) begin
    if (!running) begin
      start_i <= 1'b0;
    end else if (start_i && !item_taken) begin
      // hold the item until the block takes it
    end else begin
      item_taken = 1'b0;
      if (pending_ops.size() != 0 && !gap_armed) begin
        idle_left = pending_ops[0].gap;
        gap_armed = 1'b1;
      end
      if (pending_ops.size() == 0 || idle_left > 0 ||
          (pending_ops[0].drain && resolutions_due.size() != 0)) begin
        if (idle_left > 0) idle_left--;
        start_i <= 1'b0;
        present_op(random_op(0));
      end else begin
        issued_op = pending_ops.pop_front();
        gap_armed = 1'b0;
        start_i <= 1'b1;
        present_op(issued_op);
      end
    end
  end

  // Monitor: check results and record accepted items at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        if (resolutions_due.size() == 0) begin
          errors++;
          $display("%0t: result with none expected, actual taken %b target %h nullify %b cop %b",
                   $time, taken_o, target_pc_o, nullify_slot_o, cop_unusable_o);
        end else begin
          want = resolutions_due.pop_front();
          check_field("taken", 32'(want.taken), 32'(taken_o));
          check_field("target_pc", want.target, target_pc_o);
          check_field("nullify_slot", 32'(want.nullify), 32'(nullify_slot_o));
          check_field("cop_unusable", 32'(want.cop_fault), 32'(cop_unusable_o));
        end
      end
      if (start_i && !busy_o) begin
        resolutions_due.push_back(resolve_branch(issued_op));
        item_taken = 1'b1;
      end
    end
  end

  initial begin
    // directed: every command, undefined codes, disabled coprocessor, field extremes
    for (int k = 0; k < 24; k++) begin
      op = random_op(0);
      if (k <= int'(CMD_JR))
        op.cmd = CmdW'(k);
      else if (k == int'(CMD_JR) + 1)
        op.cmd = CMD_UNDEF_LO;
      else if (k == int'(CMD_JR) + 2)
        op.cmd = CMD_UNDEF_HI;
      else
        op.cmd = CMD_BC1F + CmdW'(k - int'(CMD_JR) - 3);
      op.rs     = corner_value(k);
      op.rt     = (k % 3 == 0) ? op.rs : corner_value(k + 2);
      op.imm    = k[0] ? 16'h8000 : 16'h7fff;
      op.pc     = k[1] ? 32'hffff_fffc : 32'h0000_0000;
      op.jidx   = k[2] ? {26{1'b1}} : 26'd0;
      op.usable = (k <= int'(CMD_JR) + 2);
      op.cond   = k[0] ^ k[1];
      op.gap    = 0;
      op.drain  = 1'b0;
      pending_ops.push_back(op);
    end
    for (int p = 0; p < 4; p++) begin
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        op = random_op(phase_idle[p]);
        // wait for the pipe to empty at each phase change
        if (n == 0) op.drain = 1'b1;
        pending_ops.push_back(op);
      end
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);
    running = 1'b1;

    while (pending_ops.size() != 0 || start_i) @(posedge clk_i);
    while (resolutions_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("TB_ERROR");
    $finish;
  end

endmodule
